/* rtl/core/hks_pkg.sv */
`timescale 1ns / 1ps
package hks_pkg;
  localparam int unsigned TableSizeDefault  = 128;
  localparam int unsigned ProbeLimitDefault = 8;
  localparam logic [31:0] MultReset   = 32'd2654435761;
  localparam logic [16:0] MaxLength   = 17'd65536;

  localparam logic [1:0] ACT_SET  = 2'd0;
  localparam logic [1:0] ACT_DEL  = 2'd1;
  localparam logic [1:0] ACT_GET  = 2'd2;
  localparam logic [1:0] ACT_ITER = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_KEY     = 3'd1;
  localparam logic [2:0] ST_FINISHED   = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  localparam logic [0:0] REG_MULT = 1'd0;

  // controller -> datapath commands
  typedef struct packed {
    logic start;      // latch input item, compute home
    logic rd;         // issue read at current index
    logic step;       // advance index by one
    logic scan_init;  // index <= start slot for iterate
    logic wr_set;     // write key/val/len/flags at hit/free
    logic wr_dead;    // mark dead at recorded hit slot
    logic load_hit;   // result from read data
    logic load_none;  // result with status only
    logic [2:0] status;
  } hks_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       used;      // slot read is used
    logic       dead;
    logic       match;     // used and key equal
    logic       hit_valid; // a matching slot was recorded
    logic       free_valid;
    logic       at_end;    // scan index is last slot
    logic       full;      // entry count reached half
    logic       len_bad;
    logic [1:0] action;
    logic       key_zero;
    logic       hit_last;  // recorded match is the last slot
  } hks_sts_t;
endpackage

/* rtl/core/hks_datapath.sv */
`timescale 1ns / 1ps
module hks_datapath
  import hks_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TableSizeDefault,
  localparam int unsigned IW = $clog2(TABLE_SIZE)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  hks_cmd_t    cmd,
  output hks_sts_t    sts,
  input  logic [31:0] mult,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  input  logic [16:0] in_value_length,
  output logic [2:0]  res_status,
  output logic [31:0] res_key,
  output logic [31:0] res_value,
  output logic [16:0] res_length
);
  logic [TABLE_SIZE-1:0] used_r, dead_r;
  logic [31:0] mem_key [TABLE_SIZE];
  logic [31:0] mem_val [TABLE_SIZE];
  logic [16:0] mem_len [TABLE_SIZE];
  logic [31:0] rkey_r, rval_r;
  logic [16:0] rlen_r;
  logic        rused_r, rdead_r;
  logic [IW-1:0] ridx_r;

  logic [1:0]  act_r;
  logic [31:0] key_r, val_r;
  logic [16:0] len_r;
  logic [IW-1:0] idx_r, hit_r, free_r;
  logic        hitv_r, freev_r;
  logic [IW:0] count_r;
  logic [31:0] prod;

  assign prod = in_key * mult;

  // item registers and probe index
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_r <= in_action;
      key_r <= in_key;
      val_r <= in_value;
      len_r <= in_value_length;
      idx_r <= prod[IW-1:0];
    end else if (cmd.scan_init) begin
      idx_r <= (sts.key_zero || !hitv_r) ? '0 : hit_r + 1'b1;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // registered read of the slot store
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rkey_r  <= mem_key[idx_r];
      rval_r  <= mem_val[idx_r];
      rlen_r  <= mem_len[idx_r];
      rused_r <= used_r[idx_r];
      rdead_r <= dead_r[idx_r];
      ridx_r  <= idx_r;
    end
  end

  // first match and first free slot of the probe
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      hitv_r  <= 1'b0;
      freev_r <= 1'b0;
    end else if (cmd.step && !cmd.scan_init) begin
      if (sts.match && !hitv_r) begin
        hitv_r <= 1'b1;
        hit_r  <= ridx_r;
      end
      if (!rused_r && !freev_r) begin
        freev_r <= 1'b1;
        free_r  <= ridx_r;
      end
    end
  end

  // slot store writes
  always_ff @(posedge clk) begin
    if (cmd.wr_set) begin
      mem_val[hitv_r ? hit_r : free_r] <= val_r;
      mem_len[hitv_r ? hit_r : free_r] <= len_r;
      if (!hitv_r) mem_key[free_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      dead_r  <= '0;
      count_r <= '0;
    end else if (cmd.wr_set) begin
      if (hitv_r) begin
        dead_r[hit_r] <= 1'b0;
      end else begin
        used_r[free_r] <= 1'b1;
        dead_r[free_r] <= 1'b0;
        count_r        <= count_r + 1'b1;
      end
    end else if (cmd.wr_dead) begin
      dead_r[hit_r] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_hit) begin
      res_status <= ST_OK;
      res_key    <= (act_r == ACT_ITER) ? rkey_r : '0;
      res_value  <= rval_r;
      res_length <= rlen_r;
    end else if (cmd.load_none) begin
      res_status <= cmd.status;
      res_key    <= '0;
      res_value  <= '0;
      res_length <= '0;
    end
  end

  assign sts.used       = rused_r;
  assign sts.dead       = rdead_r;
  assign sts.match      = rused_r && (rkey_r == key_r);
  assign sts.hit_valid  = hitv_r;
  assign sts.free_valid = freev_r;
  assign sts.at_end     = (idx_r == IW'(TABLE_SIZE - 1));
  assign sts.full       = (count_r >= (IW + 1)'(TABLE_SIZE / 2));
  assign sts.len_bad    = (len_r > MaxLength);
  assign sts.action     = act_r;
  assign sts.key_zero   = (key_r == '0);
  assign sts.hit_last   = (hit_r == IW'(TABLE_SIZE - 1));
endmodule

/* rtl/core/hks_ctrl.sv */
`timescale 1ns / 1ps
module hks_ctrl
  import hks_pkg::*;
#(
  parameter int unsigned PROBE_LIMIT = ProbeLimitDefault,
  localparam int unsigned PW = $clog2(PROBE_LIMIT + 1)
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output hks_cmd_t cmd,
  input  hks_sts_t sts
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRD   = 3'd1; // read issued
  localparam logic [2:0] S_PCHK  = 3'd2; // examine probe slot
  localparam logic [2:0] S_ACT   = 3'd3; // decide after probe
  localparam logic [2:0] S_SRD   = 3'd4; // scan read issued
  localparam logic [2:0] S_SCHK  = 3'd5; // examine scan slot
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  logic          stop;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  // probe ends at unused slot, match or window end
  assign stop = !sts.used || sts.match || (cnt_r == PW'(PROBE_LIMIT - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        // record hit/free for this slot
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (stop || sts.match) state_nxt = S_ACT;
        else state_nxt = S_PRD;
        if (!sts.used) state_nxt = S_ACT;
      end
      S_ACT: begin
        case (sts.action)
          ACT_SET: begin
            if (sts.hit_valid) begin
              cmd.wr_set = 1'b1; cmd.load_none = 1'b1; cmd.status = ST_OK;
            end else if (sts.len_bad) begin
              cmd.load_none = 1'b1; cmd.status = ST_BAD_LENGTH;
            end else if (sts.full || !sts.free_valid) begin
              cmd.load_none = 1'b1; cmd.status = ST_FULL;
            end else begin
              cmd.wr_set = 1'b1; cmd.load_none = 1'b1; cmd.status = ST_OK;
            end
            state_nxt = S_OUT;
          end
          ACT_DEL: begin
            cmd.wr_dead   = sts.hit_valid;
            cmd.load_none = 1'b1;
            cmd.status    = ST_OK;
            state_nxt     = S_OUT;
          end
          ACT_GET: begin
            // read data still holds the matching slot
            if (sts.hit_valid && !sts.dead) cmd.load_hit = 1'b1;
            else begin
              cmd.load_none = 1'b1; cmd.status = ST_NO_KEY;
            end
            state_nxt = S_OUT;
          end
          default: begin
            if (!sts.key_zero && !sts.hit_valid) begin
              cmd.load_none = 1'b1; cmd.status = ST_NO_KEY;
              state_nxt = S_OUT;
            end else if (!sts.key_zero && sts.hit_last) begin
              // hit at the last slot: nothing follows
              cmd.load_none = 1'b1; cmd.status = ST_FINISHED;
              state_nxt = S_OUT;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SRD;
            end
          end
        endcase
      end
      S_SRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (sts.used && !sts.dead) begin
          cmd.load_hit = 1'b1;
          state_nxt    = S_OUT;
        end else if (sts.at_end) begin
          cmd.load_none = 1'b1; cmd.status = ST_FINISHED;
          state_nxt = S_OUT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_OUT: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

/* rtl/core/hashed_key_store_core.sv */
`timescale 1ns / 1ps
// Open-addressed key/value table with linear probing over TABLE_SIZE slots.
// Set, delete and get probe p slots from the home slot, p being in
// 1..PROBE_LIMIT; each probed slot costs one registered read of the slot
// store and one compare. Iterate then scans on from its start slot until
// a live entry or the end of the table. One item is in work at a time; the
// next is taken once the result has been transferred.
module hashed_key_store_core
  import hks_pkg::*;
#(
  parameter int unsigned TABLE_SIZE  = TableSizeDefault,
  parameter int unsigned PROBE_LIMIT = ProbeLimitDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  input  logic [16:0] in_value_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_key,
  output logic [31:0] out_found_value,
  output logic [16:0] out_found_length,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  hks_cmd_t    cmd;
  hks_sts_t    sts;
  logic [31:0] mult_r;

  // configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= MultReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[1:1] == REG_MULT && cfg_paddr[0] == 1'b0) begin
      mult_r <= cfg_pwdata;
    end
  end
  assign cfg_prdata = (cfg_paddr == 2'd0) ? mult_r : '0;

  hks_ctrl #(.PROBE_LIMIT(PROBE_LIMIT)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  hks_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk, .rst_n, .cmd, .sts, .mult(mult_r),
    .in_action, .in_key, .in_value, .in_value_length,
    .res_status(out_status), .res_key(out_found_key),
    .res_value(out_found_value), .res_length(out_found_length)
  );
endmodule

/* rtl/core/hks_checker.sv */
`timescale 1ns / 1ps
module hks_checker
  import hks_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [16:0] out_found_length
);
  // no new transfer while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  // a result never shows up the cycle after an input transfer
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // status codes in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_FULL) else $error("bad status");
  // failures carry no length
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_found_length == '0)
    else $error("length on failure");
endmodule

bind hashed_key_store_core hks_checker u_hks_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_status, .out_found_length
);

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import hks_pkg::*;

  localparam int unsigned Slots      = TableSizeDefault;
  localparam int unsigned ProbeDepth = ProbeLimitDefault;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] key;
    logic [31:0] value;
    logic [16:0] length;
  } kv_request_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] key;
    logic [31:0] value;
    logic [16:0] length;
  } kv_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [31:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic [16:0] in_value_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_found_key;
  logic [31:0] out_found_value;
  logic [16:0] out_found_length;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  hashed_key_store_core dut (.*);

  always #2 clk = ~clk;

  // Shadow copy of the table
  logic [31:0] mirror_mult;
  bit          mirror_used [Slots];
  bit          mirror_dead [Slots];
  logic [31:0] mirror_key  [Slots];
  logic [31:0] mirror_value[Slots];
  logic [16:0] mirror_len  [Slots];
  int unsigned mirror_count;

  kv_request_t pending_requests[$];
  kv_reply_t   awaited_replies[$];
  logic [31:0] key_pool[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic recv_hold = 1'b0;
  bit  stall_req = 1'b0;
  int  errors = 0;
  int unsigned cycles = 0;

  function automatic int unsigned home_of(logic [31:0] k);
    logic [31:0] prod;
    prod = k * mirror_mult;
    return prod & (Slots - 1);
  endfunction

  function automatic int lookup_slot(logic [31:0] k);
    int unsigned idx;
    idx = home_of(k);
    for (int n = 0; n < ProbeDepth; n++) begin
      if (!mirror_used[idx]) return -1;
      if (mirror_key[idx] == k) return idx;
      idx = (idx + 1) & (Slots - 1);
    end
    return -1;
  endfunction

  function automatic int free_slot(logic [31:0] k);
    int unsigned idx;
    idx = home_of(k);
    for (int n = 0; n < ProbeDepth; n++) begin
      if (!mirror_used[idx]) return idx;
      idx = (idx + 1) & (Slots - 1);
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the reply it earns
  function automatic kv_reply_t apply_request(kv_request_t rq);
    kv_reply_t r;
    int hit;
    int fr;
    int unsigned first;
    r = '{ST_OK, 32'd0, 32'd0, 17'd0};
    hit = lookup_slot(rq.key);
    case (rq.action)
      ACT_SET: begin
        if (hit >= 0) begin
          mirror_value[hit] = rq.value;
          mirror_len[hit]   = rq.length;
          mirror_dead[hit]  = 0;
        end else if (rq.length > MaxLength) begin
          r.status = ST_BAD_LENGTH;
        end else if (mirror_count >= Slots / 2) begin
          r.status = ST_FULL;
        end else begin
          fr = free_slot(rq.key);
          if (fr < 0) begin
            r.status = ST_FULL;
          end else begin
            mirror_used[fr]  = 1;
            mirror_dead[fr]  = 0;
            mirror_key[fr]   = rq.key;
            mirror_value[fr] = rq.value;
            mirror_len[fr]   = rq.length;
            mirror_count++;
          end
        end
      end
      ACT_DEL: begin
        if (hit >= 0) mirror_dead[hit] = 1;
      end
      ACT_GET: begin
        if (hit >= 0 && !mirror_dead[hit]) begin
          r.value  = mirror_value[hit];
          r.length = mirror_len[hit];
        end else begin
          r.status = ST_NO_KEY;
        end
      end
      default: begin
        first = 0;
        if (rq.key != 0 && hit < 0) begin
          r.status = ST_NO_KEY;
        end else begin
          if (rq.key != 0) first = hit + 1;
          r.status = ST_FINISHED;
          for (int unsigned i = first; i < Slots; i++) begin
            if (mirror_used[i] && !mirror_dead[i]) begin
              r = '{ST_OK, mirror_key[i], mirror_value[i], mirror_len[i]};
              break;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Input driver: accepted transfers feed the shadow table
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        awaited_replies.push_back(apply_request('{in_action, in_key, in_value,
                                                  in_value_length}));
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid        <= 1'b1;
          in_action       <= pending_requests[0].action;
          in_key          <= pending_requests[0].key;
          in_value        <= pending_requests[0].value;
          in_value_length <= pending_requests[0].length;
          void'(pending_requests.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    kv_reply_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("unexpected result", out_status, 0);
        end else begin
          want = awaited_replies.pop_front();
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_found_key !== want.key) report_mismatch("key", out_found_key, want.key);
          if (out_found_value !== want.value)
            report_mismatch("value", out_found_value, want.value);
          if (out_found_length !== want.length)
            report_mismatch("length", out_found_length, want.length);
        end
      end
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (stall_req);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (400) @(posedge clk);
    recv_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("hashed_key_store_core: mismatch");
      $finish;
    end
  end

  task automatic write_mult(logic [31:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 2'(4 * REG_MULT);
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    mirror_mult = v;
  endtask

  function automatic logic [16:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 5) return MaxLength;
    if (r < 15) return 17'($urandom_range(131071, 65537));
    return 17'($urandom_range(65536, 0));
  endfunction

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'd0;
    if (r < 15) return $urandom;
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  task automatic queue_random(int n);
    kv_request_t rq;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      rq.action = (r < 40) ? ACT_SET : (r < 55) ? ACT_DEL : (r < 80) ? ACT_GET : ACT_ITER;
      rq.key    = pick_key();
      if (rq.action == ACT_ITER && $urandom_range(2) == 0) rq.key = 0;
      rq.value  = $urandom;
      rq.length = pick_length();
      pending_requests.push_back(rq);
    end
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && !in_valid && awaited_replies.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_directed();
    pending_requests.push_back('{ACT_SET,  32'd0,         32'd0,         17'd0});
    pending_requests.push_back('{ACT_SET,  32'hFFFFFFFF,  32'hFFFFFFFF,  MaxLength});
    pending_requests.push_back('{ACT_SET,  32'h12345678,  32'h1,         17'd65537});
    pending_requests.push_back('{ACT_SET,  32'h12345679,  32'h2,         17'h1FFFF});
    pending_requests.push_back('{ACT_GET,  32'd0,         32'd0,         17'd0});
    pending_requests.push_back('{ACT_GET,  32'hFFFFFFFF,  32'd0,         17'd0});
    pending_requests.push_back('{ACT_GET,  32'h12345678,  32'd0,         17'd0});
    pending_requests.push_back('{ACT_ITER, 32'd0,         32'd0,         17'd0});
    pending_requests.push_back('{ACT_ITER, 32'hFFFFFFFF,  32'd0,         17'd0});
    pending_requests.push_back('{ACT_ITER, 32'h12345678,  32'd0,         17'd0});
    pending_requests.push_back('{ACT_DEL,  32'hFFFFFFFF,  32'd0,         17'd0});
    pending_requests.push_back('{ACT_GET,  32'hFFFFFFFF,  32'd0,         17'd0});
    pending_requests.push_back('{ACT_ITER, 32'hFFFFFFFF,  32'd0,         17'd0});
    // revive of a dead entry skips the length check
    pending_requests.push_back('{ACT_SET,  32'hFFFFFFFF,  32'hA5A5A5A5,  17'h1FFFF});
    pending_requests.push_back('{ACT_GET,  32'hFFFFFFFF,  32'd0,         17'd0});
    pending_requests.push_back('{ACT_DEL,  32'h0BADBEEF,  32'd0,         17'd0});
    pending_requests.push_back('{ACT_DEL,  32'd0,         32'd0,         17'd0});
    pending_requests.push_back('{ACT_ITER, 32'd0,         32'd0,         17'd0});
    pending_requests.push_back('{ACT_SET,  32'd0,         32'h5A5A5A5A,  17'd1});
    pending_requests.push_back('{ACT_ITER, 32'd0,         32'd0,         17'd0});
  endtask

  initial begin
    logic [31:0] mults[6];
    mults = '{MultReset, 32'd0, 32'd1, 32'hFFFFFFFF, $urandom | 32'd1, MultReset};
    mirror_mult  = MultReset;
    mirror_count = 0;
    for (int i = 0; i < Slots; i++) begin
      mirror_used[i] = 0;
      mirror_dead[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 65 : 0;
      recv_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 21 : 0;
      write_mult(mults[ph]);
      key_pool.delete();
      for (int k = 0; k < 24; k++) key_pool.push_back($urandom);
      key_pool.push_back(32'hFFFFFFFF);
      if (ph == 0) begin
        queue_directed();
        drain();
      end
      queue_random(90);
      if (ph == 4) stall_req = 1'b1;
      // sender pauses until the table has answered everything
      drain();
      queue_random(90);
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("hashed_key_store_core: match");
    end else begin
      $display("hashed_key_store_core: mismatch");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/hks_pkg.sv
rtl/core/hks_datapath.sv
rtl/core/hks_ctrl.sv
rtl/core/hashed_key_store_core.sv
rtl/core/hks_checker.sv
tb/tb.sv
